### rtl/core/atmu_pkg.sv
// ----------------------------------------------------------------------------
// Affine transform matrix unit package
// Command codes, item and control types, and the Q16.16 saturation helper
// shared by the lanes and the top level.
// ----------------------------------------------------------------------------
package atmu_pkg;

  localparam int NUM_LANES = 4;
  localparam int ACC_W     = 52;
  localparam int ROT_SHIFT = 14;
  localparam int Q16_SHIFT = 16;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam longint             HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_ROTATE    = 3'd1,
    OP_SCALE     = 3'd2,
    OP_SET_TRANS = 3'd3,
    OP_LOAD_COL  = 3'd4,
    OP_TRANSFORM = 3'd5,
    OP_IDENTITY  = 3'd6
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic [1:0]         column_index;
    logic [11:0]        angle;
  } cmd_t;

  typedef struct packed {
    logic       mul;
    logic       apply;
    logic [1:0] step;
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

### rtl/core/atmu_if.sv
// ----------------------------------------------------------------------------
// Affine transform matrix unit channels
// Valid/ready command and result channels with their item payloads.
// ----------------------------------------------------------------------------
interface atmu_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  logic [1:0]         column_index;
  logic [11:0]        angle;

  modport source (
    output valid, operation, value_a, value_b, value_c, value_d, column_index, angle,
    input  ready
  );
  modport sink (
    input  valid, operation, value_a, value_b, value_c, value_d, column_index, angle,
    output ready
  );
endinterface

interface atmu_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

### rtl/core/atmu_sine.sv
// ----------------------------------------------------------------------------
// Affine transform matrix unit sine/cosine generator
// Three-stage pipeline: angle reduction, quadrant split, quarter-wave table
// lookup with sign fold. Table holds round(sin*16384), built at elaboration.
// ----------------------------------------------------------------------------
module atmu_sine import atmu_pkg::*; #(
  parameter int ANGLE_STEPS = 4096
) (
  input  logic               clk_i,
  input  logic [11:0]        angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam int Q   = ANGLE_STEPS / 4;
  localparam int AW  = $clog2(ANGLE_STEPS);
  localparam int AW1 = AW + 1;
  localparam int RW  = $clog2(Q + 1);

  localparam logic [16:0]    RECIP = 17'((64'd1 << 24) / ANGLE_STEPS);
  localparam logic [21:0]    STEPS = 22'(ANGLE_STEPS);
  localparam logic [AW1-1:0] Q1    = AW1'(Q);
  localparam logic [AW1-1:0] Q2    = AW1'(2 * Q);
  localparam logic [AW1-1:0] Q3    = AW1'(3 * Q);

  logic [14:0] sine_rom [Q+1];

  for (genvar k = 0; k <= Q; k++) begin : g_rom
    localparam longint X   = (longint'(k) * HALF_PI_Q30) / Q;
    localparam longint X2  = (X * X) >> 30;
    localparam longint T1  = ((X * X2) >> 30) / 6;
    localparam longint T2  = ((T1 * X2) >> 30) / 20;
    localparam longint T3  = ((T2 * X2) >> 30) / 42;
    localparam longint T4  = ((T3 * X2) >> 30) / 72;
    localparam longint T5  = ((T4 * X2) >> 30) / 110;
    localparam longint T6  = ((T5 * X2) >> 30) / 156;
    localparam longint T7  = ((T6 * X2) >> 30) / 210;
    localparam longint T8  = ((T7 * X2) >> 30) / 272;
    localparam longint T9  = ((T8 * X2) >> 30) / 342;
    localparam longint T10 = ((T9 * X2) >> 30) / 420;
    localparam longint S   = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;
    localparam longint SP  = (S < 0) ? 0 : S;
    localparam longint V   = (SP + 32768) >> 16;
    assign sine_rom[k] = 15'(V);
  end

  logic [28:0]    prod;
  logic [4:0]     q_est;
  logic [21:0]    rem;
  logic [21:0]    rem_c;
  logic [AW-1:0]  a_q;
  logic [AW1-1:0] a_ext;
  logic [AW1-1:0] r_full;
  logic [1:0]     quad_d;
  logic [1:0]     quad_q;
  logic [RW-1:0]  r_q;
  logic [14:0]    sr;
  logic [14:0]    sc;
  logic signed [15:0] sr16;
  logic signed [15:0] sc16;
  logic signed [15:0] sin_d;
  logic signed [15:0] cos_d;

  always_comb begin
    prod  = 29'(angle_i) * 29'(RECIP);
    q_est = prod[28:24];
    rem   = 22'(angle_i) - 22'(q_est) * STEPS;
    rem_c = (rem >= STEPS) ? rem - STEPS : rem;
  end

  always_comb begin
    a_ext = AW1'(a_q);
    if (a_ext >= Q3) begin
      quad_d = 2'd3;
      r_full = a_ext - Q3;
    end else if (a_ext >= Q2) begin
      quad_d = 2'd2;
      r_full = a_ext - Q2;
    end else if (a_ext >= Q1) begin
      quad_d = 2'd1;
      r_full = a_ext - Q1;
    end else begin
      quad_d = 2'd0;
      r_full = a_ext;
    end
  end

  always_comb begin
    sr   = sine_rom[r_q];
    sc   = sine_rom[RW'(Q) - r_q];
    sr16 = signed'({1'b0, sr});
    sc16 = signed'({1'b0, sc});
    case (quad_q)
      2'd0: begin
        sin_d = sr16;
        cos_d = sc16;
      end
      2'd1: begin
        sin_d = sc16;
        cos_d = -sr16;
      end
      2'd2: begin
        sin_d = -sr16;
        cos_d = -sc16;
      end
      default: begin
        sin_d = -sc16;
        cos_d = sr16;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q    <= AW'(rem_c);
    quad_q <= quad_d;
    r_q    <= RW'(r_full);
    sin_o  <= sin_d;
    cos_o  <= cos_d;
  end

endmodule

### rtl/core/atmu_lane.sv
// ----------------------------------------------------------------------------
// Affine transform matrix unit lane
// Holds one matrix row, runs one shared 32x32 multiplier per step and a
// registered shift/accumulate/saturate stage behind it.
// ----------------------------------------------------------------------------
module atmu_lane import atmu_pkg::*; #(
  parameter int ROW = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctl_t          ctl_i,
  input  cmd_t               cmd_i,
  input  logic signed [15:0] sin_i,
  input  logic signed [15:0] cos_i,
  output logic signed [31:0] res_o
);

  localparam logic [1:0] ROW_IDX = 2'(ROW);

  logic signed [31:0]      w_q [4];
  logic signed [31:0]      vec [4];
  logic signed [31:0]      vrow;
  logic signed [31:0]      opa;
  logic signed [31:0]      opb;
  logic                    mul_act;
  logic                    m_vld_q;
  op_e                     m_op_q;
  logic [1:0]              m_step_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      sh;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] sum;
  logic signed [31:0]      sum_sat;
  logic signed [31:0]      hold_q;
  logic signed [31:0]      tr_sum;
  logic                    first;
  logic                    half;
  logic                    last;

  assign vec[0] = cmd_i.value_a;
  assign vec[1] = cmd_i.value_b;
  assign vec[2] = cmd_i.value_c;
  assign vec[3] = cmd_i.value_d;
  assign vrow   = (ROW == 0) ? cmd_i.value_a : cmd_i.value_b;

  always_comb begin
    opa     = w_q[ctl_i.step];
    opb     = vec[ctl_i.step];
    mul_act = 1'b0;
    case (cmd_i.op)
      OP_TRANSFORM: begin
        mul_act = 1'b1;
      end
      OP_ROTATE: begin
        mul_act = (ROW < 2);
        case (ctl_i.step)
          2'd0: begin
            opa = w_q[0];
            opb = 32'(cos_i);
          end
          2'd1: begin
            opa = w_q[1];
            opb = -(32'(sin_i));
          end
          2'd2: begin
            opa = w_q[0];
            opb = 32'(sin_i);
          end
          default: begin
            opa = w_q[1];
            opb = 32'(cos_i);
          end
        endcase
      end
      OP_SCALE: begin
        mul_act = (ROW < 2);
        opa     = w_q[ROW_IDX];
        opb     = vrow;
      end
      default: begin
        mul_act = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= ctl_i.mul && mul_act;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= 64'(opa) * 64'(opb);
    m_op_q   <= cmd_i.op;
    m_step_q <= ctl_i.step;
  end

  always_comb begin
    if (m_op_q == OP_ROTATE) begin
      sh    = prod_q >>> ROT_SHIFT;
      first = (m_step_q == 2'd0) || (m_step_q == 2'd2);
    end else begin
      sh    = prod_q >>> Q16_SHIFT;
      first = (m_step_q == 2'd0);
    end
    half    = (m_op_q == OP_ROTATE) && (m_step_q == 2'd1);
    last    = (m_op_q == OP_SCALE) || (m_step_q == 2'd3);
    sum     = (first ? '0 : acc_q) + $signed(sh[ACC_W-1:0]);
    sum_sat = sat32(sum);
    tr_sum  = sat32(ACC_W'(w_q[3]) + ACC_W'(vrow));
  end

  assign res_o = sum_sat;

  always_ff @(posedge clk_i) begin
    if (m_vld_q) begin
      acc_q <= sum;
      if (half) begin
        hold_q <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        w_q[k] <= (k == ROW) ? ONE_Q16 : '0;
      end
    end else if (m_vld_q && last) begin
      case (m_op_q)
        OP_ROTATE: begin
          w_q[0] <= hold_q;
          w_q[1] <= sum_sat;
        end
        OP_SCALE: begin
          w_q[ROW_IDX] <= sum_sat;
        end
        default: begin
        end
      endcase
    end else if (ctl_i.apply) begin
      case (cmd_i.op)
        OP_TRANSLATE: begin
          if (ROW < 2) begin
            w_q[3] <= tr_sum;
          end
        end
        OP_SET_TRANS: begin
          if (ROW < 2) begin
            w_q[3] <= vrow;
          end
        end
        OP_LOAD_COL: begin
          w_q[cmd_i.column_index] <= vec[ROW_IDX];
        end
        OP_IDENTITY: begin
          for (int k = 0; k < 4; k++) begin
            w_q[k] <= (k == ROW) ? ONE_Q16 : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/affine_transform_matrix_unit.sv
// Transform: the item runs four multiply steps per lane on one multiplier, then
//   the drain state loads the result slot; the next command is taken in the
//   drain state, a next transform only once that load is done. Scale runs one
//   multiply step; rotate first waits in the angle state for the three-stage
//   sine/cosine table ahead of the lanes; all other commands pass the simple state.
// Reset: asynchronous active low; matrix returns to identity, result slot empty.
// ----------------------------------------------------------------------------
// Affine transform matrix unit
// Command sequencer, four row lanes, sine/cosine generator and the result
// register that merges the lane outputs into one item.
// ----------------------------------------------------------------------------
module affine_transform_matrix_unit import atmu_pkg::*; #(
  parameter int ANGLE_STEPS = 4096
) (
  input logic       clk_i,
  input logic       rst_ni,
  atmu_cmd_if.sink  cmd_i,
  atmu_res_if.source res_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SIMPLE = 3'd1;
  localparam logic [2:0] ST_ANGLE  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  cmd_t               cmd_in;
  cmd_t               cmd_q;
  lane_ctl_t          ctl;
  logic               accept;
  logic               seq_free;
  logic               slot_ok;
  logic               res_load;
  logic               res_valid_q;
  logic signed [31:0] res_q [NUM_LANES];
  logic signed [31:0] lane_res [NUM_LANES];
  logic signed [15:0] sin_w;
  logic signed [15:0] cos_w;
  logic               mul_last;

  assign cmd_in.op           = op_e'(cmd_i.operation);
  assign cmd_in.value_a      = cmd_i.value_a;
  assign cmd_in.value_b      = cmd_i.value_b;
  assign cmd_in.value_c      = cmd_i.value_c;
  assign cmd_in.value_d      = cmd_i.value_d;
  assign cmd_in.column_index = cmd_i.column_index;
  assign cmd_in.angle        = cmd_i.angle;

  assign seq_free    = (state_q == ST_IDLE) || (state_q == ST_SIMPLE) || (state_q == ST_DRAIN);
  assign res_load    = (state_q == ST_DRAIN) && (cmd_q.op == OP_TRANSFORM);
  assign slot_ok     = !res_load && !(res_valid_q && !res_o.ready);
  assign cmd_i.ready = seq_free && ((cmd_i.operation != OP_TRANSFORM) || slot_ok);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign mul_last    = (cmd_q.op == OP_SCALE) ? (cnt_q == 2'd0) : (cnt_q == 2'd3);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_ANGLE: begin
        if (cnt_q == 2'd2) begin
          state_d = ST_MUL;
          cnt_d   = 2'd0;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (seq_free && accept) begin
      cnt_d = 2'd0;
      case (cmd_in.op)
        OP_ROTATE:    state_d = ST_ANGLE;
        OP_SCALE:     state_d = ST_MUL;
        OP_TRANSFORM: state_d = ST_MUL;
        default:      state_d = ST_SIMPLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_in;
    end
  end

  assign ctl.mul   = (state_q == ST_MUL);
  assign ctl.apply = (state_q == ST_SIMPLE);
  assign ctl.step  = cnt_q;

  atmu_sine #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_sine (
    .clk_i   (clk_i),
    .angle_i (cmd_q.angle),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    atmu_lane #(
      .ROW (i)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cmd_i  (cmd_q),
      .sin_i  (sin_w),
      .cos_i  (cos_w),
      .res_o  (lane_res[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        res_q[i] <= lane_res[i];
      end
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.out_x = res_q[0];
  assign res_o.out_y = res_q[1];
  assign res_o.out_z = res_q[2];
  assign res_o.out_w = res_q[3];

endmodule

### rtl/core/atmu_checker.sv
// ----------------------------------------------------------------------------
// Affine transform matrix unit checker
// Port-level assertions on result timing and slot flow control, bound to
// the top level.
// ----------------------------------------------------------------------------
module atmu_sva import atmu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cmd_valid_i,
  input logic               cmd_ready_i,
  input logic [2:0]         cmd_operation_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic signed [31:0] out_x_i,
  input logic signed [31:0] out_y_i,
  input logic signed [31:0] out_z_i,
  input logic signed [31:0] out_w_i
);

  logic tr_accept;
  assign tr_accept = cmd_valid_i && cmd_ready_i && (cmd_operation_i == OP_TRANSFORM);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(out_x_i) && $stable(out_y_i)
      && $stable(out_z_i) && $stable(out_w_i))
    else $error("result item changed while stalled");

  a_tr_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_accept |-> ##6 res_valid_i)
    else $error("transform result missing six cycles after accept");

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(tr_accept, 6))
    else $error("result item without a matching transform");

  a_slot_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i && cmd_valid_i && (cmd_operation_i == OP_TRANSFORM)
      |-> !cmd_ready_i)
    else $error("transform accepted while result slot is stalled");

endmodule

bind affine_transform_matrix_unit atmu_sva u_atmu_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .cmd_operation_i (cmd_i.operation),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .out_x_i         (res_o.out_x),
  .out_y_i         (res_o.out_y),
  .out_z_i         (res_o.out_z),
  .out_w_i         (res_o.out_w)
);
